@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LCD_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define LCD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ hdl/lcd_pkg.sv @@
// shared types and codes of the loop chunk dispatcher
`default_nettype none
package lcd_pkg;

  localparam logic [1:0] REQ_START    = 2'd0;
  localparam logic [1:0] REQ_NEXT     = 2'd1;
  localparam logic [1:0] REQ_END      = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_ZERO_STRIDE = 2'd1;
  localparam logic [1:0] ERR_OVERSHOOT   = 2'd2;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_SET_ERR1,
    CMD_SET_ERR2,
    CMD_DIV_LIM,
    CMD_TAKE_LIM,
    CMD_CHUNK_REQ,
    CMD_DIV_CH,
    CMD_TAKE_CH,
    CMD_MUL_OVR,
    CMD_COMMIT,
    CMD_COMMIT_DYN,
    CMD_MUL_TID,
    CMD_POS_PROD,
    CMD_CLAIM,
    CMD_CLEAR_CLAIM,
    CMD_DIV_PREV,
    CMD_TAKE_OLD,
    CMD_MUL_STEP,
    CMD_POS_STEP,
    CMD_MUL_START,
    CMD_TAKE_START,
    CMD_MUL_END,
    CMD_TAKE_END,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       inc_zero;
    logic       creq_pos;
    logic       req_dyn;
    logic       stride_zero;
    logic       dyn_mode;
    logic       claim_lt_lim;
    logic       div_done;
    logic       mul_done;
    logic       ovr_bad;
    logic       tid_ok;
    logic       step_ok;
  } stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LIM_WAIT,
    ST_CH_DIV,
    ST_CH_WAIT,
    ST_CH_DONE,
    ST_OVR_WAIT,
    ST_COMMIT,
    ST_TID_MUL,
    ST_TID_WAIT,
    ST_PREV_WAIT,
    ST_STEP_MUL,
    ST_STEP_WAIT,
    ST_EMIT,
    ST_START_WAIT,
    ST_END_MUL,
    ST_END_WAIT,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

@@ hdl/lcd_div.sv @@
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module lcd_div import lcd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic [WORD_W-1:0]      quotient,
  output logic [WORD_W-1:0]      remainder
);

  localparam logic [CNT_W-1:0] STEPS = CNT_W'(WORD_W);

  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [WORD_W:0]   shifted;
  logic              ge;

  always_comb begin
    shifted = {rem_r, quo_r[WORD_W-1]};
    ge      = shifted >= {1'b0, dvsr_r};
    rem_nxt = ge ? WORD_W'(shifted - {1'b0, dvsr_r}) : shifted[WORD_W-1:0];
    quo_nxt = {quo_r[WORD_W-2:0], ge};
  end

  assign done      = busy_r && (cnt_r == '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEPS;
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lcd_mul.sv @@
// serial shift-add multiplier, low word plus overflow flag
`default_nettype none
module lcd_mul import lcd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] mcand,
  input  wire logic [WORD_W-1:0] mplier,
  output logic                   done,
  output logic [WORD_W-1:0]      product,
  output logic                   ovf
);

  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] mcand_r;
  logic [WORD_W-1:0] mplier_r;
  logic              sh_ovf_r;
  logic              ovf_r;
  logic              busy_r;
  logic [WORD_W:0]   sum;

  assign sum     = {1'b0, acc_r} + {1'b0, mcand_r};
  assign done    = busy_r && (mplier_r == '0);
  assign product = acc_r;
  assign ovf     = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // stops as soon as no multiplier bits are left
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= mcand;
      mplier_r <= mplier;
      sh_ovf_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (busy_r && mplier_r != '0) begin
      if (mplier_r[0]) begin
        acc_r <= sum[WORD_W-1:0];
        if (sum[WORD_W] || sh_ovf_r) begin
          ovf_r <= 1'b1;
        end
      end
      sh_ovf_r <= sh_ovf_r | mcand_r[WORD_W-1];
      mcand_r  <= {mcand_r[WORD_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[WORD_W-1:1]};
    end
  end

endmodule
`default_nettype wire

@@ hdl/lcd_datapath.sv @@
// loop state, request latch, arithmetic units and result registers
`default_nettype none
module lcd_datapath import lcd_pkg::*; #(
  parameter int unsigned MAX_WORKERS               = 64,
  parameter int unsigned DYNAMIC_CHUNKS_PER_WORKER = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [6:0]        cfg_wr_data,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic [1:0]        in_req_type,
  input  wire logic              in_dynamic_mode,
  input  wire logic [63:0]       in_loop_start,
  input  wire logic [63:0]       in_loop_end,
  input  wire logic [63:0]       in_loop_step,
  input  wire logic [63:0]       in_chunk_request,
  input  wire logic [5:0]        in_worker_id,
  input  wire logic [63:0]       in_prev_span_start,
  output logic                   out_got_chunk,
  output logic [63:0]            out_span_first,
  output logic [63:0]            out_span_limit,
  output logic [63:0]            out_stride,
  output logic [1:0]             out_error_code
);

  logic [6:0]  wc_r;
  logic [63:0] lim_r, base_r, stride_r, chunk_r, claim_r;
  logic        dyn_r;

  logic [1:0]  rq_kind_r;
  logic        rq_dyn_r;
  logic [63:0] rq_st_r, rq_en_r, rq_inc_r, rq_creq_r, rq_prev_r;
  logic [5:0]  rq_tid_r;

  logic [63:0] t_lim_r, t_ch_r, pos_r, pend_r;

  logic        res_got_r;
  logic [63:0] res_start_r, res_end_r, res_stride_r;
  logic [1:0]  res_err_r;

  logic        out_got_r;
  logic [63:0] out_start_r, out_end_r, out_stride_r;
  logic [1:0]  out_err_r;

  logic        div_start, div_done;
  logic [63:0] div_a, div_b, div_q, div_r;
  logic        mul_start, mul_done, mul_ovf;
  logic [63:0] mul_a, mul_b, mul_p;

  logic [63:0] lim_dividend, inc_abs, prev_dividend, stride_abs;
  logic [63:0] wc_ext, dyn_div, npos, rest, cnt, ch_default;
  logic [64:0] ovr_sum;
  logic [6:0]  wc_wr;

  lcd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  lcd_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_p),
    .ovf     (mul_ovf)
  );

  always_comb begin
    wc_ext  = {57'd0, wc_r};
    dyn_div = 64'(DYNAMIC_CHUNKS_PER_WORKER) * wc_ext;
    inc_abs = rq_inc_r[63] ? (64'd0 - rq_inc_r) : rq_inc_r;
    // empty range for the stride's sign gives a zero trip count
    if (rq_inc_r[63]) begin
      lim_dividend = ($signed(rq_en_r) <= $signed(rq_st_r)) ? rq_st_r - rq_en_r : 64'd0;
    end else begin
      lim_dividend = ($signed(rq_en_r) >= $signed(rq_st_r)) ? rq_en_r - rq_st_r : 64'd0;
    end
    stride_abs    = stride_r[63] ? (64'd0 - stride_r) : stride_r;
    prev_dividend = stride_r[63] ? base_r - rq_prev_r : rq_prev_r - base_r;
    npos          = pos_r + mul_p;
    rest          = lim_r - pos_r;
    cnt           = (chunk_r < rest) ? chunk_r : rest;
    ovr_sum       = {1'b0, mul_p} + {1'b0, t_lim_r};
    if (rq_dyn_r) begin
      ch_default = (div_q == 64'd0) ? 64'd1 : div_q;
    end else begin
      ch_default = div_q + {63'd0, (div_r != 64'd0)};
    end
    if (cfg_wr_data == 7'd0) begin
      wc_wr = 7'd1;
    end else if (32'(cfg_wr_data) > MAX_WORKERS) begin
      wc_wr = 7'(MAX_WORKERS);
    end else begin
      wc_wr = cfg_wr_data;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = lim_dividend;
    div_b     = inc_abs;
    mul_start = 1'b0;
    mul_a     = stride_r;
    mul_b     = pos_r;
    case (cmd)
      CMD_DIV_LIM: begin
        div_start = 1'b1;
      end
      CMD_DIV_CH: begin
        div_start = 1'b1;
        div_a     = t_lim_r;
        div_b     = rq_dyn_r ? dyn_div : wc_ext;
      end
      CMD_DIV_PREV: begin
        div_start = 1'b1;
        div_a     = prev_dividend;
        div_b     = stride_abs;
      end
      CMD_MUL_OVR: begin
        mul_start = 1'b1;
        mul_a     = t_ch_r;
        mul_b     = wc_ext - 64'd1;
      end
      CMD_MUL_TID: begin
        mul_start = 1'b1;
        mul_a     = chunk_r;
        mul_b     = {58'd0, rq_tid_r};
      end
      CMD_MUL_STEP: begin
        mul_start = 1'b1;
        mul_a     = chunk_r;
        mul_b     = wc_ext;
      end
      CMD_MUL_START: begin
        mul_start = 1'b1;
      end
      CMD_MUL_END: begin
        mul_start = 1'b1;
        mul_b     = pend_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.kind         = rq_kind_r;
    stat.inc_zero     = (rq_inc_r == 64'd0);
    stat.creq_pos     = (rq_creq_r != 64'd0) && !rq_creq_r[63];
    stat.req_dyn      = rq_dyn_r;
    stat.stride_zero  = (stride_r == 64'd0);
    stat.dyn_mode     = dyn_r;
    stat.claim_lt_lim = (claim_r < lim_r);
    stat.div_done     = div_done;
    stat.mul_done     = mul_done;
    stat.ovr_bad      = mul_ovf || ovr_sum[64];
    stat.tid_ok       = !mul_ovf && (mul_p < lim_r);
    stat.step_ok      = !mul_ovf && (npos > pos_r) && (npos < lim_r);
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r     <= 7'd1;
      lim_r    <= '0;
      base_r   <= '0;
      stride_r <= '0;
      chunk_r  <= '0;
      claim_r  <= '0;
      dyn_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wc_r <= wc_wr;
      end
      case (cmd)
        CMD_COMMIT, CMD_COMMIT_DYN: begin
          lim_r    <= t_lim_r;
          base_r   <= rq_st_r;
          stride_r <= rq_inc_r;
          chunk_r  <= t_ch_r;
          dyn_r    <= rq_dyn_r;
        end
        CMD_CLAIM: begin
          // saturate rather than wrap
          claim_r <= (chunk_r > ~claim_r) ? '1 : claim_r + chunk_r;
        end
        CMD_CLEAR_CLAIM: begin
          claim_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_ACCEPT: begin
        rq_kind_r    <= in_req_type;
        rq_dyn_r     <= in_dynamic_mode;
        rq_st_r      <= in_loop_start;
        rq_en_r      <= in_loop_end;
        rq_inc_r     <= in_loop_step;
        rq_creq_r    <= in_chunk_request;
        rq_tid_r     <= in_worker_id;
        rq_prev_r    <= in_prev_span_start;
        res_got_r    <= 1'b0;
        res_start_r  <= '0;
        res_end_r    <= '0;
        res_stride_r <= '0;
        res_err_r    <= ERR_NONE;
      end
      CMD_SET_ERR1:   res_err_r <= ERR_ZERO_STRIDE;
      CMD_SET_ERR2:   res_err_r <= ERR_OVERSHOOT;
      CMD_TAKE_LIM:   t_lim_r <= div_q;
      CMD_CHUNK_REQ:  t_ch_r <= rq_creq_r;
      CMD_TAKE_CH:    t_ch_r <= ch_default;
      CMD_POS_PROD:   pos_r <= mul_p;
      CMD_CLAIM:      pos_r <= claim_r;
      CMD_TAKE_OLD:   pos_r <= div_q;
      CMD_POS_STEP:   pos_r <= npos;
      CMD_MUL_START:  pend_r <= pos_r + cnt;
      CMD_TAKE_START: res_start_r <= base_r + mul_p;
      CMD_TAKE_END: begin
        res_end_r    <= base_r + mul_p;
        res_stride_r <= stride_r;
        res_got_r    <= 1'b1;
      end
      CMD_LOAD_OUT: begin
        out_got_r    <= res_got_r;
        out_start_r  <= res_start_r;
        out_end_r    <= res_end_r;
        out_stride_r <= res_stride_r;
        out_err_r    <= res_err_r;
      end
      default: begin
      end
    endcase
  end

  assign out_got_chunk  = out_got_r;
  assign out_span_first = out_start_r;
  assign out_span_limit = out_end_r;
  assign out_stride     = out_stride_r;
  assign out_error_code = out_err_r;

endmodule
`default_nettype wire

@@ hdl/lcd_ctrl.sv @@
// sequencing state machine for the dispatcher
`default_nettype none
module lcd_ctrl import lcd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (stat.kind)
          REQ_START: state_nxt = stat.inc_zero ? ST_FIN : ST_LIM_WAIT;
          REQ_NEXT: begin
            if (stat.stride_zero) begin
              state_nxt = ST_FIN;
            end else if (stat.dyn_mode) begin
              state_nxt = stat.claim_lt_lim ? ST_EMIT : ST_FIN;
            end else begin
              state_nxt = ST_PREV_WAIT;
            end
          end
          default:   state_nxt = ST_FIN;
        endcase
      end
      ST_LIM_WAIT:   if (stat.div_done) state_nxt = ST_CH_DIV;
      ST_CH_DIV:     state_nxt = stat.creq_pos ? ST_CH_DONE : ST_CH_WAIT;
      ST_CH_WAIT:    if (stat.div_done) state_nxt = ST_CH_DONE;
      ST_CH_DONE:    state_nxt = stat.req_dyn ? ST_OVR_WAIT : ST_COMMIT;
      ST_OVR_WAIT:   if (stat.mul_done) state_nxt = ST_FIN;
      ST_COMMIT:     state_nxt = ST_TID_MUL;
      ST_TID_MUL:    state_nxt = ST_TID_WAIT;
      ST_TID_WAIT:   if (stat.mul_done) state_nxt = stat.tid_ok ? ST_EMIT : ST_FIN;
      ST_PREV_WAIT:  if (stat.div_done) state_nxt = ST_STEP_MUL;
      ST_STEP_MUL:   state_nxt = ST_STEP_WAIT;
      ST_STEP_WAIT:  if (stat.mul_done) state_nxt = stat.step_ok ? ST_EMIT : ST_FIN;
      ST_EMIT:       state_nxt = ST_START_WAIT;
      ST_START_WAIT: if (stat.mul_done) state_nxt = ST_END_MUL;
      ST_END_MUL:    state_nxt = ST_END_WAIT;
      ST_END_WAIT:   if (stat.mul_done) state_nxt = ST_FIN;
      ST_FIN:        if (slot_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = CMD_NONE;
    unique case (state_r)
      ST_IDLE:     if (in_valid) cmd = CMD_ACCEPT;
      ST_DISPATCH: begin
        unique case (stat.kind)
          REQ_START: cmd = stat.inc_zero ? CMD_SET_ERR1 : CMD_DIV_LIM;
          REQ_NEXT: begin
            if (stat.stride_zero) begin
              cmd = CMD_NONE;
            end else if (stat.dyn_mode) begin
              cmd = stat.claim_lt_lim ? CMD_CLAIM : CMD_NONE;
            end else begin
              cmd = CMD_DIV_PREV;
            end
          end
          REQ_END:   cmd = CMD_CLEAR_CLAIM;
          default:   cmd = CMD_NONE;
        endcase
      end
      ST_LIM_WAIT:   if (stat.div_done) cmd = CMD_TAKE_LIM;
      ST_CH_DIV:     cmd = stat.creq_pos ? CMD_CHUNK_REQ : CMD_DIV_CH;
      ST_CH_WAIT:    if (stat.div_done) cmd = CMD_TAKE_CH;
      ST_CH_DONE:    cmd = stat.req_dyn ? CMD_MUL_OVR : CMD_NONE;
      ST_OVR_WAIT:   if (stat.mul_done) cmd = stat.ovr_bad ? CMD_SET_ERR2 : CMD_COMMIT_DYN;
      ST_COMMIT:     cmd = CMD_COMMIT;
      ST_TID_MUL:    cmd = CMD_MUL_TID;
      ST_TID_WAIT:   if (stat.mul_done && stat.tid_ok) cmd = CMD_POS_PROD;
      ST_PREV_WAIT:  if (stat.div_done) cmd = CMD_TAKE_OLD;
      ST_STEP_MUL:   cmd = CMD_MUL_STEP;
      ST_STEP_WAIT:  if (stat.mul_done && stat.step_ok) cmd = CMD_POS_STEP;
      ST_EMIT:       cmd = CMD_MUL_START;
      ST_START_WAIT: if (stat.mul_done) cmd = CMD_TAKE_START;
      ST_END_MUL:    cmd = CMD_MUL_END;
      ST_END_WAIT:   if (stat.mul_done) cmd = CMD_TAKE_END;
      ST_FIN:        if (slot_free) cmd = CMD_LOAD_OUT;
      default:       cmd = CMD_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_FIN && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/loop_chunk_dispatcher_core.sv @@
// top level of the loop chunk dispatcher
`default_nettype none
`include "assert_macros.svh"
// Hands out iteration spans of a strided loop to a pool of workers. One request is
// worked on at a time, and every request gives exactly one result transfer. A new
// request is taken once the previous one has been handed to the output register,
// even while that result still waits. All the work runs through one serial 64-bit
// divider and one shift-add multiplier that stops once no multiplier bits are left.
// Between acceptance and the loading of the result: a start with a nonzero stride
// takes one or two divider passes plus up to three multiplies; a static next one
// divide and up to three multiplies; a dynamic next up to two multiplies. An end
// request, an unused code, a zero-stride start, a next on a zero stride and a
// dynamic next with no span left use neither unit. The final state is held while
// the previous result still waits. worker_count is written through
// cfg_wr_en/cfg_wr_data and clamped to 1..MAX_WORKERS.
module loop_chunk_dispatcher_core import lcd_pkg::*; #(
  parameter int unsigned MAX_WORKERS               = 64,
  parameter int unsigned DYNAMIC_CHUNKS_PER_WORKER = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic        in_dynamic_mode,
  input  wire logic [63:0] in_loop_start,
  input  wire logic [63:0] in_loop_end,
  input  wire logic [63:0] in_loop_step,
  input  wire logic [63:0] in_chunk_request,
  input  wire logic [5:0]  in_worker_id,
  input  wire logic [63:0] in_prev_span_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_got_chunk,
  output logic [63:0]      out_span_first,
  output logic [63:0]      out_span_limit,
  output logic [63:0]      out_stride,
  output logic [1:0]       out_error_code
);

  cmd_t  cmd;
  stat_t stat;

  lcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lcd_datapath #(
    .MAX_WORKERS               (MAX_WORKERS),
    .DYNAMIC_CHUNKS_PER_WORKER (DYNAMIC_CHUNKS_PER_WORKER)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_req_type),
    .in_dynamic_mode    (in_dynamic_mode),
    .in_loop_start      (in_loop_start),
    .in_loop_end        (in_loop_end),
    .in_loop_step       (in_loop_step),
    .in_chunk_request   (in_chunk_request),
    .in_worker_id       (in_worker_id),
    .in_prev_span_start (in_prev_span_start),
    .out_got_chunk      (out_got_chunk),
    .out_span_first     (out_span_first),
    .out_span_limit     (out_span_limit),
    .out_stride         (out_stride),
    .out_error_code     (out_error_code)
  );

  // an accepted transfer keeps the block busy for at least the next cycle
  `LCD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // an error never comes with a span
  `LCD_ASSERT_NOW(a_err_no_span, clk, rst_n, out_valid && out_error_code != ERR_NONE, !out_got_chunk)
  // divider and multiplier never finish together
  `LCD_ASSERT_NOW(a_one_unit, clk, rst_n, stat.div_done, !stat.mul_done)

endmodule
`default_nettype wire

@@ test/tb_loop_chunk_dispatcher_core.sv @@
// self-checking testbench of the loop chunk dispatcher core
`timescale 1ns / 1ps
`default_nettype none
module tb_loop_chunk_dispatcher_core;
  import lcd_pkg::*;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        dynamic_mode;
    logic [63:0] loop_start;
    logic [63:0] loop_end;
    logic [63:0] loop_step;
    logic [63:0] chunk_request;
    logic [5:0]  worker_id;
    logic [63:0] prev_span_start;
  } chunk_req_t;

  typedef struct packed {
    logic        got_chunk;
    logic [63:0] span_first;
    logic [63:0] span_limit;
    logic [63:0] stride;
    logic [1:0]  error_code;
  } span_t;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  chunk_req_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  span_t out_item;

  loop_chunk_dispatcher_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_item.req_type), .in_dynamic_mode(in_item.dynamic_mode),
    .in_loop_start(in_item.loop_start), .in_loop_end(in_item.loop_end),
    .in_loop_step(in_item.loop_step), .in_chunk_request(in_item.chunk_request),
    .in_worker_id(in_item.worker_id), .in_prev_span_start(in_item.prev_span_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_got_chunk(out_item.got_chunk), .out_span_first(out_item.span_first),
    .out_span_limit(out_item.span_limit), .out_stride(out_item.stride),
    .out_error_code(out_item.error_code)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] workers = 64'd1;
  logic [63:0] trip_cnt, base_idx, step_idx, chunk_len, claim_pos;
  logic        dyn_loop;
  span_t       expected_spans[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        hold_off = 1'b0;
  int unsigned hold_left = 0;

  function automatic logic [63:0] positions_between(logic [63:0] idx, logic [63:0] base,
                                                     logic [63:0] st);
    if (!st[63]) return (idx - base) / st;
    return (base - idx) / (64'd0 - st);
  endfunction

  function automatic logic mul_fits(logic [63:0] a, logic [63:0] b, output logic [63:0] p);
    logic [127:0] full;
    full = a * b;
    p = full[63:0];
    return full[127:64] == 0;
  endfunction

  function automatic span_t make_span(logic [63:0] pos);
    span_t s;
    logic [63:0] rest, cnt;
    rest = trip_cnt - pos;
    cnt = (chunk_len < rest) ? chunk_len : rest;
    s = '0;
    s.got_chunk = 1'b1;
    s.span_first = base_idx + pos * step_idx;
    s.span_limit = base_idx + (pos + cnt) * step_idx;
    s.stride = step_idx;
    return s;
  endfunction

  function automatic span_t predict_span(chunk_req_t r);
    span_t s;
    logic [63:0] lim, ch, pos, ovr, old, stp, npos;
    s = '0;
    case (r.req_type)
      REQ_START: begin
        if (r.loop_step == 0) begin
          s.error_code = ERR_ZERO_STRIDE;
          return s;
        end
        lim = 0;
        if (!r.loop_step[63]) begin
          if ($signed(r.loop_end) >= $signed(r.loop_start))
            lim = positions_between(r.loop_end, r.loop_start, r.loop_step);
        end else if ($signed(r.loop_end) <= $signed(r.loop_start)) begin
          lim = positions_between(r.loop_end, r.loop_start, r.loop_step);
        end
        if (r.chunk_request == 0 || r.chunk_request[63]) begin
          if (!r.dynamic_mode) begin
            ch = lim / workers;
            if (ch * workers < lim) ch++;
          end else begin
            ch = lim / (64'd8 * workers);
            if (ch == 0) ch = 1;
          end
        end else begin
          ch = r.chunk_request;
        end
        if (r.dynamic_mode && (!mul_fits(workers - 1, ch, ovr) || ovr > ALL_ONES - lim)) begin
          s.error_code = ERR_OVERSHOOT;
          return s;
        end
        trip_cnt = lim; base_idx = r.loop_start; step_idx = r.loop_step;
        chunk_len = ch; dyn_loop = r.dynamic_mode;
        if (!r.dynamic_mode && mul_fits({58'd0, r.worker_id}, ch, pos) && pos < lim)
          s = make_span(pos);
      end
      REQ_NEXT: begin
        if (step_idx != 0) begin
          if (dyn_loop) begin
            pos = claim_pos;
            if (pos < trip_cnt) begin
              claim_pos = (chunk_len > ALL_ONES - pos) ? ALL_ONES : pos + chunk_len;
              s = make_span(pos);
            end
          end else begin
            old = positions_between(r.prev_span_start, base_idx, step_idx);
            if (mul_fits(workers, chunk_len, stp)) begin
              npos = old + stp;
              if (npos > old && npos < trip_cnt) s = make_span(npos);
            end
          end
        end
      end
      REQ_END: claim_pos = 0;
      default: ;
    endcase
    return s;
  endfunction

  // valid stays high after a transfer until a gap or a drain drops it
  task automatic send_request(chunk_req_t r);
    in_valid <= 1'b1;
    in_item <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_spans.push_back(predict_span(r));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (450) @(posedge clk);
  endtask

  task automatic write_workers(logic [6:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    workers = (v == 0) ? 64'd1 : (v > 64) ? 64'd64 : {57'd0, v};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic chunk_req_t start_req(logic dyn, logic [63:0] st, logic [63:0] en,
                                           logic [63:0] inc, logic [63:0] ch, logic [5:0] tid);
    chunk_req_t r;
    r = '0;
    r.req_type = REQ_START; r.dynamic_mode = dyn; r.loop_start = st; r.loop_end = en;
    r.loop_step = inc; r.chunk_request = ch; r.worker_id = tid;
    r.prev_span_start = rand64();
    return r;
  endfunction

  function automatic chunk_req_t next_req(logic [63:0] prev);
    chunk_req_t r;
    r = '0;
    r.req_type = REQ_NEXT; r.prev_span_start = prev; r.loop_start = rand64();
    return r;
  endfunction

  // random burst gap between transfers
  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    chunk_req_t r;
    send_request(next_req(64'd0));
    send_request(start_req(0, 0, 100, 0, 0, 0));
    send_request(start_req(0, 0, 100, 1, 0, 0));
    send_request(next_req(64'd0));
    send_request(start_req(0, 100, 0, -64'sd3, 7, 5));
    send_request(next_req(64'd100));
    send_request(start_req(0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0, 63));
    send_request(next_req(64'h8000_0000_0000_0000));
    send_request(start_req(0, 0, 10, 1, 64'h7FFF_FFFF_FFFF_FFFF, 63));
    send_request(next_req(64'd0));
    send_request(start_req(1, 0, 50, 2, 64'h8000_0000_0000_0000, 0));
    repeat (4) send_request(next_req(64'd0));
    r = '0; r.req_type = REQ_END; send_request(r);
    send_request(next_req(64'd0));
    r = '0; r.req_type = REQ_RESERVED; r.loop_step = 1; send_request(r);
    send_request(start_req(0, 5, 0, 1, 0, 0));
    send_request(next_req(64'd5));
    send_request(start_req(1, 0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0));
    send_request(start_req(1, 0, 20, 1, 1, 0));
    drain();
  endtask

  task automatic test_random(int unsigned n);
    chunk_req_t r;
    logic [63:0] st, inc, prev;
    for (int unsigned i = 0; i < n; i++) begin
      sender_gap();
      r = '0;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          st = ($urandom_range(0, 4) == 0) ? rand64() : {{32{$urandom_range(0,1)==1}}, $urandom()};
          inc = ($urandom_range(0, 5) == 0) ? rand64() : $urandom_range(1, 9);
          if ($urandom_range(0, 1)) inc = -inc;
          if ($urandom_range(0, 15) == 0) inc = 0;
          r = start_req($urandom_range(0, 1), st,
                        ($urandom_range(0, 4) == 0) ? rand64()
                        : st + inc * $urandom_range(0, 400) + $urandom_range(0, 3),
                        inc, ($urandom_range(0, 2) == 0) ? rand64() : $urandom_range(0, 40),
                        $urandom_range(0, 63));
        end
        3, 4, 5, 6, 7: begin
          prev = base_idx + step_idx * $urandom_range(0, 400);
          r = next_req(($urandom_range(0, 7) == 0) ? rand64() : prev);
        end
        8: begin
          r.req_type = REQ_END;
          r.loop_step = rand64();
        end
        default: begin
          r = start_req($urandom_range(0, 1), rand64(), rand64(), rand64(), rand64(),
                        $urandom_range(0, 63));
          r.req_type = ($urandom_range(0, 3) == 0) ? REQ_RESERVED : REQ_START;
          r.prev_span_start = rand64();
        end
      endcase
      send_request(r);
    end
    drain();
  endtask

  // receiver holds off on its own while the sender keeps offering
  task automatic test_backpressure();
    hold_off <= 1'b1;
    @(posedge clk);
    hold_off <= 1'b0;
    for (int i = 0; i < 6; i++) begin
      send_request(start_req(0, 0, 1000, 1, 0, i));
    end
    drain();
  endtask

  // receiver stall pattern, with a long counted hold when asked for
  always @(posedge clk) begin
    if (hold_off) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (cycles[9:7] == 3'd5) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    span_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected transfer %p", $time, out_item);
        errors++;
      end else begin
        want = expected_spans.pop_front();
        if (out_item !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    trip_cnt = 0; base_idx = 0; step_idx = 0; chunk_len = 0; claim_pos = 0; dyn_loop = 0;
    test_directed();
    write_workers(7'd64);
    test_directed();
    write_workers(7'd0);
    test_random(150);
    write_workers(7'd127);
    test_random(150);
    test_backpressure();
    write_workers(7'd3);
    test_random(150);
    write_workers(7'd1);
    test_random(150);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/lcd_pkg.sv
hdl/lcd_div.sv
hdl/lcd_mul.sv
hdl/lcd_datapath.sv
hdl/lcd_ctrl.sv
hdl/loop_chunk_dispatcher_core.sv
test/tb_loop_chunk_dispatcher_core.sv
